[rtl/arpc_pkg.sv]
package arpc_pkg;

    // default sizes for the top level parameters
    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int AGE_BITS_DEF      = 16;

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int STATUS_W   = 2;
    localparam int EXPIRED_W  = 5;
    localparam int LIFETIME_W = 16;

    localparam logic [IP_W-1:0]       IP_INVALID     = '1;
    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 16'd300;
    localparam logic [EXPIRED_W-1:0]  EXPIRED_MAX    = '1;

    // operation codes carried in tuser of the request side
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    // result codes carried in tuser of the result side
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISS    = 2'd1,
        STATUS_INVALID = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

endpackage

[rtl/arp_cache_table.sv]
// ARP cache: up to TABLE_ENTRIES entries mapping an IPv4 address to a MAC
// address and a static flag. A request (tuser = operation) does a lookup, an
// add, a delete or an aging tick; each gives one result (tuser = status).
// The entry store is a RAM with one registered read port, scanned one slot per
// cycle; every request scans the whole table except a lookup, add or delete
// with the all-ones address, which goes straight to its result. A new request
// is taken once the previous one has been committed, even while its result
// still waits in the output register. Valid bits sit in flops, so no clearing
// pass follows reset. The user must write entry_lifetime through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not enforce it.
module arp_cache_table
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int AGE_BITS      = AGE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ip_addr[31:0], mac_addr[79:32], static_flag[80], zero fill [87:81]
    input  logic [87:0]           s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]     s_tuser,
    // result side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // found_mac[47:0], found_static[48], expired_count[53:49], zero fill [55:54]
    output logic [55:0]           m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser,
    // entry_lifetime register
    input  logic                  cfg_we,
    input  logic [LIFETIME_W-1:0] cfg_wdata
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = IP_W + MAC_W + 1 + AGE_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [32:0]      AGE_MAX_W = (33'd1 << AGE_BITS) - 33'd1;

    state_t state_reg, state_next;

    logic [LIFETIME_W-1:0]    lifetime_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    // latched request
    func_t           func_reg;
    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             static_reg;
    logic             invalid_reg;

    // scan pipeline
    logic [IDX_W-1:0] scan_idx_reg;
    logic             issue_done_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    // scan results
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [MAC_W-1:0] hit_mac_reg;
    logic             hit_static_reg;
    logic [EXPIRED_W-1:0] expired_reg;

    // output register
    logic                 m_tvalid_reg;
    status_t              status_reg;
    logic [MAC_W-1:0]     found_mac_reg;
    logic                 found_static_reg;
    logic [EXPIRED_W-1:0] expired_out_reg;

    // ram ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    // fields of the word read back
    logic [IP_W-1:0]     rd_ip;
    logic [MAC_W-1:0]    rd_mac;
    logic                rd_static;
    logic [AGE_BITS-1:0] rd_age;

    logic                in_accept;
    logic                out_free;
    logic                chk_valid;
    logic                chk_match;
    logic                tick_expire;
    logic                add_ok;
    logic [IDX_W-1:0]    add_idx;
    logic [AGE_BITS-1:0] life_age;
    logic [32:0]         life_w;
    status_t             status_next;

    assign {rd_ip, rd_mac, rd_static, rd_age} = ram_rdata;

    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign chk_valid   = valid_reg[chk_idx_reg];
    assign chk_match   = chk_vld_reg && chk_valid && (rd_ip == ip_reg);
    assign tick_expire = rd_age <= AGE_BITS'(1);
    assign add_ok      = hit_reg || free_reg;
    assign add_idx     = hit_reg ? hit_idx_reg : free_idx_reg;

    // lifetime clipped to the age counter range
    assign life_w   = 33'(lifetime_reg);
    assign life_age = (life_w > AGE_MAX_W) ? AGE_BITS'(AGE_MAX_W) : AGE_BITS'(life_w);

    arpc_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((func_t'(s_tuser) != FUNC_TICK) && (s_tdata[31:0] == IP_INVALID))
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_done_reg && !chk_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and ram control
    always_comb
    begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = {rd_ip, rd_mac, rd_static, rd_age - AGE_BITS'(1)};
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re = !issue_done_reg;
                // age count down written back in place
                if (func_reg == FUNC_TICK && chk_vld_reg && chk_valid && !rd_static
                    && !tick_expire)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (out_free && func_reg == FUNC_ADD && !invalid_reg && add_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = add_idx;
                    ram_wdata = {ip_reg, mac_reg, static_reg,
                                 static_reg ? AGE_BITS'(0) : life_age};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result status
    always_comb
    begin
        status_next = STATUS_OK;
        if (invalid_reg)
        begin
            status_next = STATUS_INVALID;
        end
        else
        begin
            unique case (func_reg)
                FUNC_LOOKUP: status_next = hit_reg ? STATUS_OK : STATUS_MISS;
                FUNC_ADD:    status_next = add_ok ? STATUS_OK : STATUS_FULL;
                FUNC_DELETE: status_next = hit_reg ? STATUS_OK : STATUS_MISS;
                FUNC_TICK:   status_next = STATUS_OK;
                default:     status_next = STATUS_OK;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lifetime_reg <= LIFETIME_RESET;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end

            // scan pipeline valid
            if (in_accept)
            begin
                chk_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                chk_vld_reg <= !issue_done_reg;
            end

            // aging frees expired dynamic entries
            if (state_reg == ST_SCAN && func_reg == FUNC_TICK && chk_vld_reg && chk_valid
                && !rd_static && tick_expire)
            begin
                valid_reg[chk_idx_reg] <= 1'b0;
            end

            // commit of add and delete
            if (state_reg == ST_COMMIT && out_free && !invalid_reg)
            begin
                if (func_reg == FUNC_ADD && add_ok)
                begin
                    valid_reg[add_idx] <= 1'b1;
                end
                if (func_reg == FUNC_DELETE && hit_reg)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end

            // output result handshake
            if (state_reg == ST_COMMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // latch request and start scan
        if (in_accept)
        begin
            func_reg       <= func_t'(s_tuser);
            ip_reg         <= s_tdata[31:0];
            mac_reg        <= s_tdata[79:32];
            static_reg     <= s_tdata[80];
            invalid_reg    <= (func_t'(s_tuser) != FUNC_TICK) && (s_tdata[31:0] == IP_INVALID);
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            expired_reg    <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            // address issue
            if (!issue_done_reg)
            begin
                chk_idx_reg  <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == IDX_LAST)
                begin
                    issue_done_reg <= 1'b1;
                end
            end

            // first matching entry
            if (chk_match && !hit_reg)
            begin
                hit_reg        <= 1'b1;
                hit_idx_reg    <= chk_idx_reg;
                hit_mac_reg    <= rd_mac;
                hit_static_reg <= rd_static;
            end

            // lowest free slot
            if (chk_vld_reg && !chk_valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= chk_idx_reg;
            end

            // expired count, saturating
            if (func_reg == FUNC_TICK && chk_vld_reg && chk_valid && !rd_static
                && tick_expire && expired_reg != EXPIRED_MAX)
            begin
                expired_reg <= expired_reg + EXPIRED_W'(1);
            end
        end

        // result payload
        if (state_reg == ST_COMMIT && out_free)
        begin
            status_reg <= status_next;
            if (!invalid_reg && func_reg == FUNC_LOOKUP && hit_reg)
            begin
                found_mac_reg    <= hit_mac_reg;
                found_static_reg <= hit_static_reg;
            end
            else
            begin
                found_mac_reg    <= '0;
                found_static_reg <= 1'b0;
            end
            expired_out_reg <= (func_reg == FUNC_TICK) ? expired_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {2'b00, expired_out_reg, found_static_reg, found_mac_reg};

endmodule

[rtl/arpc_entry_ram.sv]
module arpc_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 97
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
